// ===== rtl/core/sjf_pkg.sv =====
`timescale 1ns / 1ps

package sjf_pkg;

   // Default capacity of the job store.
   localparam int NUM_JOBS_DEF = 16;

   // Field widths of a job and of a result.
   localparam int ID_W    = 8;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 24;

   // One stored job: id, arrival and burst packed side by side.
   localparam int ENTRY_W = ID_W + ARR_W + BURST_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_CALC
   } sjf_state_type;

endpackage

// ===== rtl/core/sjf_ram.sv =====
`timescale 1ns / 1ps

module sjf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/shortest_job_first_scheduler_top.sv =====
`timescale 1ns / 1ps

// Non-preemptive shortest-job-first scheduler. Jobs are loaded one per request
// transaction into a single job memory; the transaction with req_last_job set
// closes the set and starts scheduling from tick zero (jobs beyond NUM_JOBS are
// dropped). Each scheduling decision sweeps the stored jobs through the one
// read port of the job memory, one entry per cycle, and then forms the result
// once the output register is free; when no job has arrived yet the clock
// jumps to the earliest pending arrival, which costs one more sweep, so a set
// of N jobs needs up to N extra sweeps for idle gaps. Requests are stalled
// from the end of loading until the last result of the set has been produced;
// a finished result waits in the output register while the next sweep runs.
module shortest_job_first_scheduler_top #(
   parameter int NUM_JOBS = sjf_pkg::NUM_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sjf_pkg::ID_W-1:0]     req_job_id,
   input  logic [sjf_pkg::ARR_W-1:0]    req_arrival_time,
   input  logic [sjf_pkg::BURST_W-1:0]  req_burst_time,
   input  logic                         req_last_job,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sjf_pkg::ID_W-1:0]     rsp_run_job_id,
   output logic [sjf_pkg::TIME_W-1:0]   rsp_start_time,
   output logic [sjf_pkg::TIME_W-1:0]   rsp_completion_time,
   output logic [sjf_pkg::TIME_W-1:0]   rsp_waiting_time,
   output logic [sjf_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic                         rsp_last_result
);
   import sjf_pkg::*;

   localparam int IDX_W = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
   localparam int CNT_W = $clog2(NUM_JOBS + 1);

   sjf_state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    finished_ff, finished_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic [TIME_W-1:0]   clock_ff, clock_in;
   logic [NUM_JOBS-1:0] done_ff, done_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [BURST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]    pick_idx_ff, pick_idx_in;
   logic [ARR_W-1:0]    pick_arr_ff, pick_arr_in;
   logic [ID_W-1:0]     pick_id_ff, pick_id_in;
   logic [ARR_W-1:0]    next_arr_ff, next_arr_in;

   logic [ID_W-1:0]     rsp_id_ff;
   logic [TIME_W-1:0]   rsp_start_ff, rsp_comp_ff, rsp_wait_ff, rsp_turn_ff;
   logic                rsp_last_ff, rsp_last_in;
   logic                load_rsp;

   logic                wr_en, rd_en;
   logic [ENTRY_W-1:0]  wr_data, rd_data;

   logic [ID_W-1:0]     ent_id;
   logic [ARR_W-1:0]    ent_arr;
   logic [BURST_W-1:0]  ent_burst;
   logic                eligible, arrived, take, pend_take, scan_end, issue;
   logic                req_acc, slot_free;
   logic                found_nx, pend_nx;
   logic [ARR_W-1:0]    next_arr_nx;
   logic [TIME_W-1:0]   completion, waiting, turnaround;

   sjf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign wr_data = {req_job_id, req_arrival_time, req_burst_time};
   assign {ent_id, ent_arr, ent_burst} = rd_data;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Evaluation of the entry returned by the job memory this cycle.
   assign eligible  = rd_valid_ff && !done_ff[rd_idx_ff];
   assign arrived   = TIME_W'(ent_arr) <= clock_ff;
   assign take      = eligible && arrived && (!found_ff || (ent_burst < best_ff));
   assign pend_take = eligible && !arrived && (!pend_ff || (ent_arr < next_arr_ff));
   assign found_nx    = found_ff || take;
   assign pend_nx     = pend_ff || pend_take;
   assign next_arr_nx = pend_take ? ent_arr : next_arr_ff;
   assign scan_end  = rd_valid_ff && (CNT_W'(rd_idx_ff) == (count_ff - CNT_W'(1)));
   assign issue     = (state_ff == ST_SCAN) && (addr_ff < count_ff);

   assign completion = clock_ff + TIME_W'(best_ff);
   assign waiting    = clock_ff - TIME_W'(pick_arr_ff);
   assign turnaround = waiting + TIME_W'(best_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      addr_in      = addr_ff;
      clock_in     = clock_ff;
      done_in      = done_ff;
      found_in     = found_nx;
      pend_in      = pend_nx;
      best_in      = take ? ent_burst : best_ff;
      pick_idx_in  = take ? rd_idx_ff : pick_idx_ff;
      pick_arr_in  = take ? ent_arr : pick_arr_ff;
      pick_id_in   = take ? ent_id : pick_id_ff;
      next_arr_in  = next_arr_nx;
      rd_valid_in  = issue;
      rd_idx_in    = addr_ff[IDX_W-1:0];
      rsp_last_in  = 1'b0;
      load_rsp     = 1'b0;
      wr_en        = 1'b0;
      rd_en        = issue;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CNT_W'(NUM_JOBS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last_job) begin
                  state_in    = ST_SCAN;
                  addr_in     = '0;
                  clock_in    = '0;
                  finished_in = '0;
                  found_in    = 1'b0;
                  pend_in     = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (scan_end) begin
               if (found_nx) begin
                  state_in = ST_CALC;
               end else begin
                  // Nothing has arrived: jump to the earliest pending arrival.
                  clock_in = TIME_W'(next_arr_nx);
                  addr_in  = '0;
                  found_in = 1'b0;
                  pend_in  = 1'b0;
               end
            end
         end
         ST_CALC: begin
            if (slot_free) begin
               load_rsp             = 1'b1;
               clock_in             = completion;
               done_in[pick_idx_ff] = 1'b1;
               finished_in          = finished_ff + CNT_W'(1);
               addr_in              = '0;
               found_in             = 1'b0;
               pend_in              = 1'b0;
               if ((finished_ff + CNT_W'(1)) == count_ff) begin
                  rsp_last_in = 1'b1;
                  state_in    = ST_LOAD;
                  count_in    = '0;
                  finished_in = '0;
                  done_in     = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         finished_ff  <= '0;
         addr_ff      <= '0;
         clock_ff     <= '0;
         done_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         addr_ff      <= addr_in;
         clock_ff     <= clock_in;
         done_ff      <= done_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      pick_idx_ff <= pick_idx_in;
      pick_arr_ff <= pick_arr_in;
      pick_id_ff  <= pick_id_in;
      next_arr_ff <= next_arr_in;
      if (load_rsp) begin
         rsp_id_ff    <= pick_id_ff;
         rsp_start_ff <= clock_ff;
         rsp_comp_ff  <= completion;
         rsp_wait_ff  <= waiting;
         rsp_turn_ff  <= turnaround;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_run_job_id      = rsp_id_ff;
   assign rsp_start_time      = rsp_start_ff;
   assign rsp_completion_time = rsp_comp_ff;
   assign rsp_waiting_time    = rsp_wait_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_last_result     = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_JOBS))
      else $error("job count exceeds capacity");

   a_finished_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (finished_ff < count_ff))
      else $error("finished count reached job count while scheduling");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("job memory data returned outside a sweep");

   a_last_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_last_job) |=> (state_ff == ST_SCAN))
      else $error("closing transaction did not start scheduling");

   a_calc_fills_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && slot_free) |=> rsp_valid_ff)
      else $error("result was not placed in the output register");

endmodule
